/* hdl/rgbh_pkg.sv */
// Package for the RGB colour histogram: widths, command codes, controller states,
// divider handshake types and the level-threshold helpers.
// Has no dependencies; every other file of the block imports it.
`default_nettype none

package rgbh_pkg;

	// Histogram geometry.
	localparam int LEVELS     = 16;
	localparam int LVL_W      = $clog2(LEVELS);
	localparam int ADDR_W     = 3 * LVL_W;
	localparam int COUNT_BITS = 20;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	// Pixel channels and bin width.
	localparam int CH_W    = 8;
	localparam int WIDTH_W = 9;
	localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(32);
	localparam int THR_W   = WIDTH_W + LVL_W;
	localparam logic [THR_W-1:0] CH_SPAN = THR_W'(1 << CH_W);

	// Frequency as an unsigned Q1.16 fraction.
	localparam int FRAC_BITS = 16;
	localparam int FREQ_W    = FRAC_BITS + 1;
	localparam logic [FREQ_W-1:0] FREQ_ONE = FREQ_W'(1 << FRAC_BITS);
	localparam int NUM_W     = COUNT_BITS + FRAC_BITS;
	localparam int DIV_CNT_W = $clog2(NUM_W);

	// Stream packing.
	localparam int IN_FIELDS_W  = 3 * CH_W + 3 * LVL_W;
	localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = 2 * COUNT_BITS + FREQ_W + 1;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_ADD   = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_RUN,
		ST_DIV
	} state_t;

	typedef struct packed {
		logic start;
		logic ack;
	} div_ctl_t;

	typedef logic [LEVELS-1:1][THR_W-1:0] thr_vec_t;

	// Lower edge of every level above zero: k times the effective bin width.
	function automatic thr_vec_t thr_of(input logic [WIDTH_W-1:0] w);
		logic [WIDTH_W-1:0] eff;
		thr_vec_t t;
		eff = (w == '0) ? WIDTH_W'(1) : w;
		for (int k = 1; k < LEVELS; k++) begin
			t[k] = THR_W'(k) * {{LVL_W{1'b0}}, eff};
		end
		return t;
	endfunction

	// A level is in use when its lower edge lies inside the channel range.
	function automatic logic [LEVELS-1:0] lvl_ok_of(input thr_vec_t t);
		logic [LEVELS-1:0] ok;
		ok[0] = 1'b1;
		for (int k = 1; k < LEVELS; k++) begin
			ok[k] = (t[k] < CH_SPAN);
		end
		return ok;
	endfunction

endpackage

`default_nettype wire

/* hdl/rgbh_div.sv */
// Restoring divider for the bin frequency, one quotient bit per cycle.
// Depends on rgbh_pkg for widths and the divider handshake struct.
`default_nettype none

module rgbh_div
	import rgbh_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire div_ctl_t              ctl,
	input  wire logic [NUM_W-1:0]      dividend,
	input  wire logic [COUNT_BITS-1:0] divisor,
	output logic                       done,
	output logic [NUM_W-1:0]           quotient
);

	logic [NUM_W-1:0]      num_q;
	logic [COUNT_BITS-1:0] rem_q;
	logic [COUNT_BITS-1:0] den_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [COUNT_BITS:0]   trial;
	logic [COUNT_BITS+1:0] diff;
	logic                  fits;

	// The partial remainder with the next dividend bit shifted in.
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, den_q};
	assign fits  = ~diff[COUNT_BITS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + DIV_CNT_W'(1);
			if (cnt_q == DIV_CNT_W'(NUM_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else if (ctl.ack) begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			num_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], fits};
			rem_q <= fits ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = num_q;

endmodule

`default_nettype wire

/* hdl/rgb_color_histogram_unit.sv */
// Top level of the joint RGB colour histogram: bin memory, add pipeline and controller.
// Depends on rgbh_pkg and instantiates the frequency divider rgbh_div.
`default_nettype none

// The block keeps a 16 x 16 x 16 histogram of pixel colours in a 4096-entry memory
// of 20-bit saturating counters. Each transfer on the s_axis channel carries a
// command in tuser (clear, add pixel, read bin, no operation) and the pixel or the
// bin levels in tdata. Every command returns exactly one transfer on m_axis with
// the bin count, the frequency count/total in Q1.16, the pixel total and the
// saturation flag. The bin width is written through the cfg channel, which is
// always ready; it should be written only while the block is idle.
// Add pixel and no-operation commands stream at one transfer per cycle while the
// output has room: the bin is read in the accept cycle and written back as the item
// leaves stage 1, and a back-to-back hit on the same bin is forwarded from the last
// write. Their result is loaded into the output register as they leave stage 1.
// A read waits for the bin read, then runs the divider, one quotient bit per cycle;
// no transfer is taken meanwhile. A clear returns its result at once and then
// sweeps all 4096 memory entries, one per cycle, while s_axis_tready stays low.
// After reset the same clearing pass runs before the first transfer.
// When the receiver stalls, the output register holds its result and the stage
// behind it holds one more item; tready drops until the output drains.

module rgb_color_histogram_unit
	import rgbh_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// s_axis_tdata, from bit 0: red, green, blue, read_red_level,
	// read_green_level, read_blue_level, zero padding.
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	// s_axis_tuser: command.
	input  wire logic [1:0]            s_axis_tuser,
	// m_axis_tdata, from bit 0: bin_count, frequency, pixel_total, saturated,
	// zero padding.
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0]      m_axis_tdata,
	// Configuration write channel: bin_width.
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [WIDTH_W-1:0]    cfg_data
);

	// Input field unpacking.
	logic [CH_W-1:0]  in_red, in_green, in_blue;
	logic [LVL_W-1:0] in_rd_r, in_rd_g, in_rd_b;
	cmd_t             in_cmd;

	assign in_red   = s_axis_tdata[CH_W-1:0];
	assign in_green = s_axis_tdata[2*CH_W-1:CH_W];
	assign in_blue  = s_axis_tdata[3*CH_W-1:2*CH_W];
	assign in_rd_r  = s_axis_tdata[3*CH_W+LVL_W-1:3*CH_W];
	assign in_rd_g  = s_axis_tdata[3*CH_W+2*LVL_W-1:3*CH_W+LVL_W];
	assign in_rd_b  = s_axis_tdata[3*CH_W+3*LVL_W-1:3*CH_W+2*LVL_W];
	assign in_cmd   = cmd_t'(s_axis_tuser);

	// Level edges follow the configured bin width; they are recomputed on each
	// configuration write so that quantising is a row of compares.
	thr_vec_t          thr_q;
	logic [LEVELS-1:0] lvl_ok_q;
	thr_vec_t          thr_cfg;

	assign cfg_ready = 1'b1;
	assign thr_cfg   = thr_of(cfg_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= thr_of(WIDTH_RESET);
			lvl_ok_q <= lvl_ok_of(thr_of(WIDTH_RESET));
		end else if (cfg_valid && cfg_ready) begin
			thr_q    <= thr_cfg;
			lvl_ok_q <= lvl_ok_of(thr_cfg);
		end
	end

	// The level of a channel is the number of level edges at or below it,
	// which also caps it at the top level.
	function automatic logic [LVL_W-1:0] quant(input logic [CH_W-1:0] c,
			input thr_vec_t t);
		logic [LVL_W-1:0] q;
		q = '0;
		for (int k = 1; k < LEVELS; k++) begin
			if ({{(THR_W-CH_W){1'b0}}, c} >= t[k]) begin
				q = q + LVL_W'(1);
			end
		end
		return q;
	endfunction

	// Controller.
	state_t state_q, state_d;
	logic   sweep_we;
	logic   div_take;
	logic   in_accept;
	logic   out_free;

	// Stage 1: the item whose bin has just been read.
	logic              valid_s1;
	cmd_t              cmd_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              rd_ok_s1;
	logic              s1_adv;

	logic [ADDR_W-1:0] clr_cnt_q;
	logic              clr_last;

	assign in_accept = s_axis_tvalid && s_axis_tready;
	assign out_free  = !m_axis_tvalid || m_axis_tready;
	assign clr_last  = (clr_cnt_q == {ADDR_W{1'b1}});

	// A read moves on to the divider; everything else needs room at the output.
	assign s1_adv = valid_s1 && ((cmd_s1 == CMD_READ) || out_free);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_last) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (s1_adv && (cmd_s1 == CMD_CLEAR)) begin
					state_d = ST_CLEAR;
				end else if (s1_adv && (cmd_s1 == CMD_READ)) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_take) state_d = ST_RUN;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	div_ctl_t         div_ctl;
	logic             div_done;
	logic [NUM_W-1:0] div_quot;

	always_comb begin
		s_axis_tready = 1'b0;
		sweep_we      = 1'b0;
		div_take      = 1'b0;
		unique case (state_q)
			ST_CLEAR: sweep_we = 1'b1;
			ST_RUN: begin
				// Clear and read take over the memory or the result path once
				// they leave stage 1, so nothing follows them in that cycle.
				s_axis_tready = !valid_s1 ||
					(s1_adv && (cmd_s1 != CMD_READ) && (cmd_s1 != CMD_CLEAR));
			end
			ST_DIV: div_take = div_done && out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (sweep_we) clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
		end
	end

	// Bin memory with registered read data.
	logic [COUNT_BITS-1:0] mem [0:(1<<ADDR_W)-1];
	logic [COUNT_BITS-1:0] mem_rd_q;
	logic [ADDR_W-1:0]     rd_addr;
	logic [ADDR_W-1:0]     wr_addr;
	logic [COUNT_BITS-1:0] wr_data;
	logic                  mem_we;

	assign rd_addr = (in_cmd == CMD_READ) ? {in_rd_r, in_rd_g, in_rd_b} :
		{quant(in_red, thr_q), quant(in_green, thr_q), quant(in_blue, thr_q)};

	always_ff @(posedge clk) begin
		if (mem_we) mem[wr_addr] <= wr_data;
		if (in_accept) mem_rd_q <= mem[rd_addr];
	end

	// Last write, forwarded when the next item hits the same bin before the
	// write has reached its read.
	logic                  wr_vld_q;
	logic [ADDR_W-1:0]     wr_addr_q;
	logic [COUNT_BITS-1:0] wr_data_q;
	logic [COUNT_BITS-1:0] bin_cur;
	logic                  bin_full;
	logic [COUNT_BITS-1:0] bin_new;
	logic                  add_we;

	assign bin_cur  = (wr_vld_q && (wr_addr_q == addr_s1)) ? wr_data_q : mem_rd_q;
	assign bin_full = (bin_cur == COUNT_MAX);
	assign bin_new  = bin_full ? bin_cur : bin_cur + COUNT_BITS'(1);
	assign add_we   = s1_adv && (cmd_s1 == CMD_ADD);

	assign mem_we  = sweep_we || add_we;
	assign wr_addr = sweep_we ? clr_cnt_q : addr_s1;
	assign wr_data = sweep_we ? '0 : bin_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_vld_q <= 1'b0;
		end else if (sweep_we) begin
			wr_vld_q <= 1'b0;
		end else if (add_we) begin
			wr_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (add_we) begin
			wr_addr_q <= addr_s1;
			wr_data_q <= bin_new;
		end
	end

	// Stage 1 registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_s1   <= in_cmd;
			addr_s1  <= rd_addr;
			rd_ok_s1 <= lvl_ok_q[in_rd_r] && lvl_ok_q[in_rd_g] && lvl_ok_q[in_rd_b];
		end
	end

	// Pixel total and saturation flag.
	logic [COUNT_BITS-1:0] pixels_q;
	logic                  sat_q;
	logic                  tot_full;
	logic [COUNT_BITS-1:0] tot_new;
	logic                  sat_new;

	assign tot_full = (pixels_q == COUNT_MAX);
	assign tot_new  = tot_full ? pixels_q : pixels_q + COUNT_BITS'(1);
	assign sat_new  = sat_q || bin_full || tot_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixels_q <= '0;
			sat_q    <= 1'b0;
		end else if (s1_adv && (cmd_s1 == CMD_CLEAR)) begin
			pixels_q <= '0;
			sat_q    <= 1'b0;
		end else if (add_we) begin
			pixels_q <= tot_new;
			sat_q    <= sat_new;
		end
	end

	// Frequency divider; a bin of an unused level reads as zero.
	logic [COUNT_BITS-1:0] rd_count_q;
	logic [COUNT_BITS-1:0] rd_count;

	assign rd_count      = rd_ok_s1 ? bin_cur : '0;
	assign div_ctl.start = s1_adv && (cmd_s1 == CMD_READ);
	assign div_ctl.ack   = div_take;

	always_ff @(posedge clk) begin
		if (div_ctl.start) rd_count_q <= rd_count;
	end

	rgbh_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend ({rd_count, {FRAC_BITS{1'b0}}}),
		.divisor  (pixels_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	logic [FREQ_W-1:0] freq;

	always_comb begin
		if (pixels_q == '0) begin
			freq = '0;
		end else if (div_quot > NUM_W'(FREQ_ONE)) begin
			freq = FREQ_ONE;
		end else begin
			freq = div_quot[FREQ_W-1:0];
		end
	end

	// Output register.
	logic                  out_valid_q;
	logic [COUNT_BITS-1:0] out_count_q;
	logic [FREQ_W-1:0]     out_freq_q;
	logic [COUNT_BITS-1:0] out_total_q;
	logic                  out_sat_q;
	logic                  s1_done;

	assign s1_done = s1_adv && (cmd_s1 != CMD_READ);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_done || div_take) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (div_take) begin
			out_count_q <= rd_count_q;
			out_freq_q  <= freq;
			out_total_q <= pixels_q;
			out_sat_q   <= sat_q;
		end else if (s1_done) begin
			out_count_q <= '0;
			out_freq_q  <= '0;
			case (cmd_s1)
				CMD_CLEAR: begin
					out_total_q <= '0;
					out_sat_q   <= 1'b0;
				end
				CMD_ADD: begin
					out_total_q <= tot_new;
					out_sat_q   <= sat_new;
				end
				default: begin
					out_total_q <= pixels_q;
					out_sat_q   <= sat_q;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W-OUT_FIELDS_W){1'b0}},
		out_sat_q, out_total_q, out_freq_q, out_count_q};

endmodule

`default_nettype wire

/* hdl/rgbh_chk.sv */
// Port-level checker for the RGB colour histogram, bound to the top level.
// Depends on rgbh_pkg for field widths and the Q1.16 unit value.
`default_nettype none

module rgbh_chk
	import rgbh_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  m_axis_tvalid,
	input wire logic                  m_axis_tready,
	input wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

	logic [COUNT_BITS-1:0] o_count;
	logic [FREQ_W-1:0]     o_freq;
	logic [COUNT_BITS-1:0] o_total;

	assign o_count = m_axis_tdata[COUNT_BITS-1:0];
	assign o_freq  = m_axis_tdata[COUNT_BITS+FREQ_W-1:COUNT_BITS];
	assign o_total = m_axis_tdata[2*COUNT_BITS+FREQ_W-1:COUNT_BITS+FREQ_W];

	a_out_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result transfer withdrawn while stalled");

	a_out_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_freq_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> o_freq <= FREQ_ONE)
		else $error("frequency above one");

	a_freq_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (o_freq == FREQ_ONE) |-> o_count == o_total)
		else $error("full frequency without the bin holding every pixel");

	a_freq_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (o_freq != '0) |-> (o_count != '0) && (o_total != '0))
		else $error("nonzero frequency for an empty bin or empty histogram");

endmodule

bind rgb_color_histogram_unit rgbh_chk u_rgbh_chk (.*);

`default_nettype wire

/* verif/rgb_histogram_monitor.sv */
// Passive monitor for the RGB colour histogram: predicts each result from the
// accepted commands and compares it with the result transfers on m_axis.
// Depends on rgbh_pkg for widths and the command codes.
`default_nettype none

module rgb_histogram_monitor
	import rgbh_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	input  wire logic                  s_axis_tready,
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	input  wire logic [1:0]            s_axis_tuser,
	input  wire logic                  m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	input  wire logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  wire logic                  cfg_valid,
	input  wire logic                  cfg_ready,
	input  wire logic [WIDTH_W-1:0]    cfg_data,
	output int                         fail_count,
	output int                         pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RED_LSB   = 0;
	localparam int GREEN_LSB = CH_W;
	localparam int BLUE_LSB  = 2 * CH_W;
	localparam int RLVL_LSB  = 3 * CH_W;
	localparam int GLVL_LSB  = 3 * CH_W + LVL_W;
	localparam int BLVL_LSB  = 3 * CH_W + 2 * LVL_W;
	localparam int NUM_BINS  = LEVELS * LEVELS * LEVELS;

	// Same layout as m_axis_tdata, bin_count in the lowest bits.
	typedef struct packed {
		logic                  saturated;
		logic [COUNT_BITS-1:0] pixel_total;
		logic [FREQ_W-1:0]     frequency;
		logic [COUNT_BITS-1:0] bin_count;
	} bin_report_t;

	logic [COUNT_BITS-1:0] bin_tally [NUM_BINS];
	logic [COUNT_BITS-1:0] pixel_tally;
	logic                  sat_flag;
	logic [WIDTH_W-1:0]    bin_width;
	bin_report_t           expected_reports [$];

	function automatic int eff_width();
		return (bin_width == '0) ? 1 : int'(bin_width);
	endfunction

	function automatic int level_of(input logic [CH_W-1:0] ch);
		int q;
		q = int'(ch) / eff_width();
		return (q > LEVELS - 1) ? LEVELS - 1 : q;
	endfunction

	function automatic int levels_in_use();
		int n;
		n = (256 + eff_width() - 1) / eff_width();
		return (n > LEVELS) ? LEVELS : n;
	endfunction

	// Saturating increment; a counter stuck at its maximum raises the flag.
	function automatic logic [COUNT_BITS-1:0] bumped(input logic [COUNT_BITS-1:0] c);
		if (c == COUNT_MAX) begin
			sat_flag = 1'b1;
			return c;
		end
		return c + 1'b1;
	endfunction

	function automatic bin_report_t tally_command(input cmd_t cmd,
			input logic [IN_DATA_W-1:0] d);
		bin_report_t rep;
		int idx;
		int n;
		logic [LVL_W-1:0] rl;
		logic [LVL_W-1:0] gl;
		logic [LVL_W-1:0] bl;
		logic [NUM_W-1:0] quot;
		rep = '0;
		rl = d[RLVL_LSB +: LVL_W];
		gl = d[GLVL_LSB +: LVL_W];
		bl = d[BLVL_LSB +: LVL_W];
		case (cmd)
			CMD_CLEAR: begin
				foreach (bin_tally[i]) bin_tally[i] = '0;
				pixel_tally = '0;
				sat_flag = 1'b0;
			end
			CMD_ADD: begin
				idx = (level_of(d[RED_LSB +: CH_W]) * LEVELS
					+ level_of(d[GREEN_LSB +: CH_W])) * LEVELS
					+ level_of(d[BLUE_LSB +: CH_W]);
				bin_tally[idx] = bumped(bin_tally[idx]);
				pixel_tally = bumped(pixel_tally);
			end
			CMD_READ: begin
				n = levels_in_use();
				if (int'(rl) < n && int'(gl) < n && int'(bl) < n) begin
					rep.bin_count = bin_tally[{rl, gl, bl}];
					if (pixel_tally != '0) begin
						quot = {rep.bin_count, {FRAC_BITS{1'b0}}} / NUM_W'(pixel_tally);
						rep.frequency = (quot > NUM_W'(FREQ_ONE)) ? FREQ_ONE : FREQ_W'(quot);
					end
				end
			end
			default: ;
		endcase
		rep.pixel_total = pixel_tally;
		rep.saturated = sat_flag;
		return rep;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bin_report_t got;
		bin_report_t want;
		bin_report_t fresh_rep;
		if (!arst_n) begin
			foreach (bin_tally[i]) bin_tally[i] = '0;
			pixel_tally = '0;
			sat_flag = 1'b0;
			bin_width = WIDTH_RESET;
			expected_reports.delete();
			fail_count <= 0;
			pending_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				bin_width = cfg_data;
			if (s_axis_tvalid && s_axis_tready) begin
				fresh_rep = tally_command(cmd_t'(s_axis_tuser), s_axis_tdata);
				expected_reports.insert(expected_reports.size(), fresh_rep);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[OUT_FIELDS_W-1:0];
				if (expected_reports.size() == 0) begin
					if (fail_count < 10)
						$display({"%0t: result with none outstanding: ",
							"count %0d freq %0d total %0d sat %0b"},
							$realtime, got.bin_count, got.frequency,
							got.pixel_total, got.saturated);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_reports.pop_front();
					if (got !== want) begin
						if (fail_count < 10)
							$display({"%0t: mismatch count %0d/%0d freq %0d/%0d ",
								"total %0d/%0d sat %0b/%0b (exp/got)"},
								$realtime, want.bin_count, got.bin_count,
								want.frequency, got.frequency,
								want.pixel_total, got.pixel_total,
								want.saturated, got.saturated);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending_count <= expected_reports.size();
		end
	end

endmodule

`default_nettype wire

/* verif/tb_rgb_color_histogram_unit.sv */
// Top of the histogram testbench: clock, reset, command stimulus, bin width
// phases, receiver back-pressure and the verdict. Depends on rgbh_pkg, the block
// rgb_color_histogram_unit and the monitor rgb_histogram_monitor.
`default_nettype none

module tb_rgb_color_histogram_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import rgbh_pkg::*;

	// A clear sweeps all 4096 bins with the input closed, and so does the pass
	// after reset; the limit on quiet cycles leaves a wide margin over both.
	localparam int STALL_LIMIT      = 20000;
	localparam int PALETTE_SIZE     = 4;
	localparam int RANDOM_PER_PHASE = 95;
	localparam int NUM_PHASES       = 11;
	localparam int SETTLE_CYCLES    = 64;

	typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY} rx_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	// s_axis_tdata, from bit 0: red, green, blue, read_red_level,
	// read_green_level, read_blue_level, zero padding.
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	// s_axis_tuser: command.
	logic [1:0]            s_axis_tuser = CMD_NOP;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// m_axis_tdata, from bit 0: bin_count, frequency, pixel_total, saturated,
	// zero padding.
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [WIDTH_W-1:0]    cfg_data = '0;

	int                    fail_count;
	int                    pending_count;
	rx_mode_t              rx_mode = RX_FREE;
	bit                    gaps_on;
	int                    stall_left = 0;
	int                    quiet_cycles = 0;
	logic [WIDTH_W-1:0]    cur_width;
	logic [CH_W-1:0]       palette [PALETTE_SIZE][3];
	int unsigned           phase_widths [9] = '{16, 256, 255, 17, 0, 5, 300, 511, 64};

	rgb_color_histogram_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	rgb_histogram_monitor u_monitor (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Receiver back-pressure. In the free mode the output is always drained; the
	// other modes stall now and then, and occasionally for a long stretch, so that
	// stalls land on every phase of the block's work.
	always @(posedge clk) begin
		int roll;
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else begin
			roll = $urandom_range(0, 99);
			if (rx_mode == RX_FREE || roll < ((rx_mode == RX_LIGHT) ? 80 : 45)) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b0;
				stall_left = (roll >= 97) ? $urandom_range(10, 40) : $urandom_range(0, 3);
			end
		end
	end

	// Watchdog: any transfer on any channel counts as progress.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Idle cycles before a command: mostly none, sometimes a few, rarely many.
	function automatic int pick_gap();
		int roll;
		if (!gaps_on)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return 0;
		if (roll < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Level that a channel value falls into at the current width; used only to
	// aim reads at bins that the palette actually fills.
	function automatic logic [LVL_W-1:0] aim_level(input logic [CH_W-1:0] ch);
		int q;
		q = int'(ch) / ((cur_width == '0) ? 1 : int'(cur_width));
		return LVL_W'((q > LEVELS - 1) ? LEVELS - 1 : q);
	endfunction

	// One command transfer. The valid stays high straight into the next command
	// when no gap is drawn, so back-to-back streaming gets exercised.
	task automatic send_item(input cmd_t cmd, input logic [CH_W-1:0] r, g, b,
			input logic [LVL_W-1:0] rl, gl, bl);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= IN_DATA_W'({bl, gl, rl, b, g, r});
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// Add a pixel; the level fields carry noise.
	task automatic add_pixel(input logic [CH_W-1:0] r, g, b);
		send_item(CMD_ADD, r, g, b, LVL_W'($urandom), LVL_W'($urandom), LVL_W'($urandom));
	endtask

	// Read a bin; the pixel fields carry noise.
	task automatic read_bin(input logic [LVL_W-1:0] rl, gl, bl);
		send_item(CMD_READ, CH_W'($urandom), CH_W'($urandom), CH_W'($urandom), rl, gl, bl);
	endtask

	// Hold off until every outstanding result has come back and the block has
	// reopened its input, which also covers the memory sweep after a clear.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0 || !s_axis_tready) @(posedge clk);
	endtask

	// Width changes are made only with the block idle.
	task automatic set_width(input logic [WIDTH_W-1:0] w);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= w;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		cur_width = w;
	endtask

	task automatic new_palette();
		foreach (palette[i, c]) palette[i][c] = CH_W'($urandom);
	endtask

	// Mostly adds drawn from a small palette, so that bins fill up and reads
	// return sizeable frequencies; the rest are reads, no-ops and rare clears.
	task automatic random_item();
		int roll;
		int k;
		roll = $urandom_range(0, 99);
		k = $urandom_range(0, PALETTE_SIZE - 1);
		if (roll < 78) begin
			if ($urandom_range(0, 3) != 0)
				add_pixel(palette[k][0], palette[k][1], palette[k][2]);
			else
				add_pixel(CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
		end else if (roll < 95) begin
			if ($urandom_range(0, 2) != 0)
				read_bin(aim_level(palette[k][0]), aim_level(palette[k][1]),
					aim_level(palette[k][2]));
			else
				read_bin(LVL_W'($urandom), LVL_W'($urandom), LVL_W'($urandom));
		end else if (roll < 98) begin
			send_item(CMD_NOP, CH_W'($urandom), CH_W'($urandom), CH_W'($urandom),
				LVL_W'($urandom), LVL_W'($urandom), LVL_W'($urandom));
		end else begin
			send_item(CMD_CLEAR, CH_W'($urandom), CH_W'($urandom), CH_W'($urandom),
				LVL_W'($urandom), LVL_W'($urandom), LVL_W'($urandom));
		end
		// Now and then the sender waits for the block to catch up completely.
		if ($urandom_range(0, 99) < 2)
			drain();
	endtask

	initial begin
		cur_width = WIDTH_RESET;
		gaps_on = 1'b1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		rx_mode <= RX_LIGHT;

		// Directed part at the reset width of 32, which leaves levels 8 to 15
		// unused. A read on the empty histogram must give zero frequency.
		read_bin(0, 0, 0);
		add_pixel(8'h00, 8'h00, 8'h00);
		add_pixel(8'hFF, 8'hFF, 8'hFF);
		add_pixel(8'hAA, 8'h55, 8'h80);
		add_pixel(8'h55, 8'hAA, 8'h7F);
		// Channel values either side of a level boundary.
		add_pixel(8'd31, 8'd32, 8'd224);
		read_bin(0, 0, 0);
		read_bin(7, 7, 7);
		read_bin(5, 2, 4);
		read_bin(0, 1, 7);
		// Level indexes past the level count read as empty.
		read_bin(8, 0, 0);
		read_bin(15, 15, 15);
		send_item(CMD_NOP, 8'hFF, 8'hFF, 8'hFF, 4'hF, 4'hF, 4'hF);
		send_item(CMD_CLEAR, 8'hFF, 8'hFF, 8'hFF, 4'hF, 4'hF, 4'hF);
		read_bin(7, 7, 7);
		// Three hits on one bin with nothing else: the frequency reaches one.
		add_pixel(8'd200, 8'd10, 8'd90);
		add_pixel(8'd200, 8'd10, 8'd90);
		add_pixel(8'd200, 8'd10, 8'd90);
		read_bin(6, 0, 2);
		read_bin(0, 0, 0);
		send_item(CMD_NOP, 8'h00, 8'h00, 8'h00, 4'h0, 4'h0, 4'h0);

		new_palette();
		repeat (RANDOM_PER_PHASE) random_item();

		// Width phases: the range limits, all-ones and single-bit patterns, widths
		// below the range (zero among them) that saturate the level, widths above
		// 256 that fold everything into level zero, then random legal widths.
		// Bins are kept across some width changes and cleared on others.
		for (int p = 0; p < NUM_PHASES; p++) begin
			set_width((p < 9) ? WIDTH_W'(phase_widths[p]) : WIDTH_W'($urandom_range(16, 256)));
			gaps_on = (p % 4 != 3);
			rx_mode <= (p % 4 == 3) ? RX_FREE : ((p % 2 == 0) ? RX_LIGHT : RX_HEAVY);
			new_palette();
			if ($urandom_range(0, 1) == 1)
				send_item(CMD_CLEAR, CH_W'($urandom), CH_W'($urandom), CH_W'($urandom),
					LVL_W'($urandom), LVL_W'($urandom), LVL_W'($urandom));
			repeat (RANDOM_PER_PHASE) random_item();
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire
